// ===== src/mpwm_pkg.sv =====
package mpwm_pkg;

	localparam int MPWM_CHANNELS   = 4;
	localparam int MPWM_COUNT_BITS = 16;

	localparam int DUTY_BITS  = 16;
	localparam int LIMIT_BITS = 32;
	localparam int MASK_BITS  = 4;
	localparam int CH_BITS    = 2;
	localparam int CFG_BITS   = 32;

	localparam logic [DUTY_BITS-1:0] PERIOD_RESET = 16'd10000;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_START,
		MODE_STOP,
		MODE_SET
	} mpwm_mode_t;

	typedef enum logic [1:0] {
		REG_PERIOD,
		REG_LIMIT,
		REG_INVERT,
		REG_ENABLE
	} mpwm_reg_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0] duty_value;
		logic [CH_BITS-1:0]   channel;
		mpwm_mode_t           mode;
	} mpwm_item_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0]  period_ticks;
		logic [LIMIT_BITS-1:0] cycle_limit;
		logic [MASK_BITS-1:0]  invert_mask;
		logic [MASK_BITS-1:0]  channel_enable_mask;
	} mpwm_cfg_t;

	// Packed so that pin_levels sits in the lowest bits.
	typedef struct packed {
		logic                 sequence_end;
		logic                 cycle_start;
		logic                 playing;
		logic [MASK_BITS-1:0] pin_levels;
	} mpwm_result_t;

endpackage

// ===== src/multichannel_pwm_generator_core.sv =====
// Channel   Direction  Bits                                     Fields
// s_*       in         tuser[1:0]                               mode
//                      tdata[1:0], tdata[17:2], 23:18 zero      channel, duty_value
// m_*       out        tdata[3:0], [4], [5], [6], 7 zero        pin_levels, playing,
//                                                               cycle_start, sequence_end
// cfg_*     in         cfg_index selects, cfg_data[31:0]        four registers
//
// One item is accepted per clock cycle while s_tready is high. The item is held in the input
// register, and its result is then written into the output buffer, which offers it on m_*.
// Reset clears the channel state, the counters and the registers to their defaults.
// A two-entry output buffer lets the input register hand over one more item during an
// output stall; s_tready then drops until the buffer is back down to one entry.
module multichannel_pwm_generator_core #(
	parameter int CHANNELS   = mpwm_pkg::MPWM_CHANNELS,
	parameter int COUNT_BITS = mpwm_pkg::MPWM_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // channel, duty_value
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // pin_levels, playing, cycle_start, sequence_end
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mpwm_pkg::*;

	mpwm_cfg_t    cfg_q;
	mpwm_item_t   item_s1;
	logic         valid_s1;
	logic         fire;
	logic         skid_ready;
	mpwm_result_t result;
	mpwm_result_t out_data;

	assign fire     = valid_s1 && skid_ready;
	assign s_tready = !valid_s1 || skid_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks        <= PERIOD_RESET;
			cfg_q.cycle_limit         <= '0;
			cfg_q.invert_mask         <= '0;
			cfg_q.channel_enable_mask <= '0;
		end else if (cfg_we) begin
			unique case (mpwm_reg_t'(cfg_index))
				REG_PERIOD: cfg_q.period_ticks        <= cfg_data[DUTY_BITS-1:0];
				REG_LIMIT:  cfg_q.cycle_limit         <= cfg_data[LIMIT_BITS-1:0];
				REG_INVERT: cfg_q.invert_mask         <= cfg_data[MASK_BITS-1:0];
				REG_ENABLE: cfg_q.channel_enable_mask <= cfg_data[MASK_BITS-1:0];
				default:    cfg_q                     <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode       <= mpwm_mode_t'(s_tuser);
			item_s1.channel    <= s_tdata[CH_BITS-1:0];
			item_s1.duty_value <= s_tdata[CH_BITS+DUTY_BITS-1:CH_BITS];
		end
	end

	mpwm_core #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	mpwm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (result),
		.ready     (skid_ready),
		.valid     (m_tvalid),
		.pop_ready (m_tready),
		.data      (out_data)
	);

	assign m_tdata = {1'b0, out_data};

endmodule

// ===== src/mpwm_core.sv =====
module mpwm_core #(
	parameter int CHANNELS   = mpwm_pkg::MPWM_CHANNELS,
	parameter int COUNT_BITS = mpwm_pkg::MPWM_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  mpwm_pkg::mpwm_item_t item,
	input  mpwm_pkg::mpwm_cfg_t  cfg,
	output mpwm_pkg::mpwm_result_t result
);
	import mpwm_pkg::*;

	// Compare width covering both the position (plus carry) and a duty value.
	localparam int W = (COUNT_BITS + 1 > DUTY_BITS) ? COUNT_BITS + 1 : DUTY_BITS;

	logic [DUTY_BITS-1:0]  duty_q [CHANNELS];
	logic [CHANNELS-1:0]   tog_q;
	logic [COUNT_BITS-1:0] pos_q;
	logic [LIMIT_BITS-1:0] cycles_q;
	logic                  active_q;
	logic [CHANNELS-1:0]   level_q;

	logic [DUTY_BITS-1:0]  duty_n [CHANNELS];
	logic [CHANNELS-1:0]   tog_n;
	logic [COUNT_BITS-1:0] pos_n;
	logic [LIMIT_BITS-1:0] cycles_n;
	logic                  active_n;
	logic [CHANNELS-1:0]   level_n;
	logic                  cstart;
	logic                  send;

	logic [CHANNELS+MASK_BITS-1:0] inv_pad;
	logic [CHANNELS+MASK_BITS-1:0] lvl_pad;
	logic [CHANNELS-1:0]           inv;
	logic [COUNT_BITS:0]           next_pos;
	logic                          wrap;
	logic [LIMIT_BITS-1:0]         cycles_inc;
	logic [DUTY_BITS-1:0]          clamped;
	logic                          set_tog;

	assign inv_pad    = {{CHANNELS{1'b0}}, cfg.invert_mask};
	assign inv        = inv_pad[CHANNELS-1:0];
	assign next_pos   = {1'b0, pos_q} + {{COUNT_BITS{1'b0}}, 1'b1};
	assign wrap       = W'(next_pos) >= W'(cfg.period_ticks);
	assign cycles_inc = cycles_q + {{(LIMIT_BITS-1){1'b0}}, 1'b1};
	assign clamped    = (item.duty_value <= cfg.period_ticks) ? item.duty_value
	                                                           : cfg.period_ticks;
	assign set_tog    = (item.duty_value != '0) && (item.duty_value < cfg.period_ticks);

	always_comb begin
		duty_n   = duty_q;
		tog_n    = tog_q;
		pos_n    = pos_q;
		cycles_n = cycles_q;
		active_n = active_q;
		level_n  = level_q;
		cstart   = 1'b0;
		send     = 1'b0;
		unique case (item.mode)
			MODE_TICK: begin
				if (active_q) begin
					if (wrap) begin
						if (cfg.cycle_limit != '0) begin
							cycles_n = cycles_inc;
						end
						if (cfg.cycle_limit != '0 && cycles_inc >= cfg.cycle_limit) begin
							active_n = 1'b0;
							send     = 1'b1;
							pos_n    = next_pos[COUNT_BITS-1:0];
						end else begin
							pos_n  = '0;
							cstart = 1'b1;
							for (int c = 0; c < CHANNELS; c++) begin
								if (tog_q[c]) begin
									level_n[c] = !inv[c];
								end
							end
						end
					end else begin
						pos_n = next_pos[COUNT_BITS-1:0];
						for (int c = 0; c < CHANNELS; c++) begin
							if (tog_q[c] && W'(duty_q[c]) == W'(next_pos[COUNT_BITS-1:0])) begin
								level_n[c] = !level_q[c];
							end
						end
					end
				end
			end
			MODE_START: begin
				// Static channels take their fixed level; toggling ones start active.
				for (int c = 0; c < CHANNELS; c++) begin
					if (tog_q[c]) begin
						level_n[c] = !inv[c];
					end else begin
						level_n[c] = inv[c] ? (duty_q[c] == '0) : (duty_q[c] != '0);
					end
				end
				cycles_n = '0;
				active_n = 1'b1;
				pos_n    = '0;
				cstart   = 1'b1;
			end
			MODE_STOP: begin
				active_n = 1'b0;
				level_n  = '0;
			end
			MODE_SET: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (int'(item.channel) == c) begin
						duty_n[c] = clamped;
						tog_n[c]  = set_tog;
						if (!set_tog && active_q) begin
							level_n[c] = inv[c] ? (clamped == '0) : (clamped != '0);
						end
					end
				end
			end
			default: begin
				active_n = active_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				duty_q[c] <= '0;
			end
			tog_q    <= '0;
			pos_q    <= '0;
			cycles_q <= '0;
			active_q <= 1'b0;
			level_q  <= '0;
		end else if (fire) begin
			duty_q   <= duty_n;
			tog_q    <= tog_n;
			pos_q    <= pos_n;
			cycles_q <= cycles_n;
			active_q <= active_n;
			level_q  <= level_n;
		end
	end

	assign lvl_pad = {{MASK_BITS{1'b0}}, level_n};

	assign result.pin_levels   = lvl_pad[MASK_BITS-1:0] & cfg.channel_enable_mask;
	assign result.playing      = active_n;
	assign result.cycle_start  = cstart;
	assign result.sequence_end = send;

endmodule

// ===== src/mpwm_skid.sv =====
module mpwm_skid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mpwm_pkg::mpwm_result_t push_data,
	output logic                   ready,
	output logic                   valid,
	input  logic                   pop_ready,
	output mpwm_pkg::mpwm_result_t data
);
	import mpwm_pkg::*;

	mpwm_result_t head_q;
	mpwm_result_t spare_q;
	logic [1:0]   count_q;
	logic         pop;

	assign valid = count_q != 2'd0;
	assign ready = count_q != 2'd2;
	assign pop   = valid && pop_ready;
	assign data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// The head entry always holds the oldest item; the spare one catches a stall.
	always_ff @(posedge clk) begin
		if (push && pop) begin
			head_q <= push_data;
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				spare_q <= push_data;
			end
		end else if (pop) begin
			head_q <= spare_q;
		end
	end

endmodule

// ===== src/mpwm_checker.sv =====
module mpwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// A stalled result must wait unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A period cannot begin on the same item that ends the sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
		else $error("cycle_start and sequence_end together");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> !m_tdata[4])
		else $error("still playing at sequence end");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> m_tdata[4])
		else $error("period began while not playing");

endmodule

bind multichannel_pwm_generator_core mpwm_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
